// ===== src/gss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg: shared types and constants for the goal shuttle steering block
// Command codes, motion codes, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int STEP_W       = 4;
    localparam int VEC_W        = 21;  // +-255*1024 per axis, magnitude grows by ~1.65*sqrt2
    localparam int ANG_W        = 18;  // 1/256 degree, within +-~72000
    localparam int ERR_W        = 14;  // 1/16 degree, within +-5760

    localparam logic signed [ERR_W-1:0] HALF_TURN16  = 14'sd2880;
    localparam logic signed [ERR_W-1:0] FULL_TURN16  = 14'sd5760;
    localparam logic [ERR_W-1:0]        FWD_WINDOW16 = 14'd320;
    localparam logic signed [ANG_W-1:0] HALF_TURN256 = 18'sd46080;
    // ceil(2^16/19); exact floor(m/19) for m below 4681
    localparam logic [11:0]             RECIP19      = 12'd3450;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_FIX   = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_LEFT  = 2'd2,
        MODE_RIGHT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_RED_X    = 3'd0,
        REG_RED_Y    = 3'd1,
        REG_GREEN_X  = 3'd2,
        REG_GREEN_Y  = 3'd3,
        REG_STR_L    = 3'd4,
        REG_STR_R    = 3'd5,
        REG_TURN_L   = 3'd6,
        REG_TURN_R   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AIM,
        ST_ROT,
        ST_ERR,
        ST_DIV,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, run tick/start/ignore
        logic aim;       // apply goal switch rules and set up CORDIC
        logic rot;       // one CORDIC iteration
        logic err;       // form wrapped bearing error
        logic div;       // |err|/19 by reciprocal multiply
        logic decide;    // pick motion and end expired turn
        logic [STEP_W-1:0] step;
    } gss_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_fix;    // request is a fix that must be processed
        logic div_done;
    } gss_stat_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            4'd0:    v = 18'sd11520;
            4'd1:    v = 18'sd6801;
            4'd2:    v = 18'sd3593;
            4'd3:    v = 18'sd1824;
            4'd4:    v = 18'sd916;
            4'd5:    v = 18'sd458;
            4'd6:    v = 18'sd229;
            4'd7:    v = 18'sd115;
            4'd8:    v = 18'sd57;
            4'd9:    v = 18'sd29;
            4'd10:   v = 18'sd14;
            4'd11:   v = 18'sd7;
            4'd12:   v = 18'sd4;
            4'd13:   v = 18'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/gss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_ctrl: sequencer for the goal shuttle steering block
// Walks a fix through goal update, CORDIC, error and turn length.
// ----------------------------------------------------------------------------
module gss_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               res_load,
    input  logic               res_busy,
    input  gss_pkg::gss_stat_t stat,
    output gss_pkg::gss_cmd_t  cmd
);
    import gss_pkg::*;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid) state_next = ST_AIM;
            ST_AIM:
            begin
                step_next  = '0;
                state_next = stat.is_fix ? ST_ROT : ST_OUT;
            end
            ST_ROT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_ERR;
            end
            ST_ERR:
                state_next = ST_DIV;
            ST_DIV:
                if (stat.div_done) state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = ST_OUT;
            ST_OUT:
                if (!res_busy) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.step   = step_reg;
        in_ready   = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_AIM:    cmd.aim    = 1'b1;
            ST_ROT:    cmd.rot    = 1'b1;
            ST_ERR:    cmd.err    = 1'b1;
            ST_DIV:    cmd.div    = 1'b1;
            ST_DECIDE: cmd.decide = 1'b1;
            ST_OUT:    res_load   = !res_busy;
            default:   ;
        endcase
    end

endmodule

// ===== src/gss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_datapath: state, config registers and arithmetic
// Holds steering state, the CORDIC vector and a reciprocal divide by 19.
// ----------------------------------------------------------------------------
module gss_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr,
    input  logic [2:0]        cfg_addr,
    input  logic [7:0]        cfg_data,
    input  logic [16:0]       in_data,
    input  gss_pkg::gss_cmd_t cmd,
    output gss_pkg::gss_stat_t stat,
    output logic [7:0]        left_drive,
    output logic [7:0]        right_drive,
    output logic [1:0]        motion,
    output logic              aim_green
);
    import gss_pkg::*;

    logic [7:0] cfg_reg [8];

    mode_t      mode_reg, mode_next;
    logic [7:0] goal_x_reg, goal_y_reg;
    logic       green_reg, started_reg;
    logic [31:0] tick_reg, mst_reg;
    logic [7:0] tlen_reg, lm_reg, rm_reg;

    logic [1:0] rcmd_reg;
    logic [4:0] px_reg, py_reg, hc_reg;

    logic signed [VEC_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic                    zero_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [7:0]              quot_reg;

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++) cfg_reg[i] <= '0;
        end
        else if (cfg_wr)
        begin
            cfg_reg[cfg_addr] <= cfg_data;
        end
    end

    function automatic logic [15:0] drives(input mode_t m, input logic [7:0] c [8]);
        case (m)
            MODE_FWD:   return {c[REG_STR_R], c[REG_STR_L]};
            MODE_LEFT:  return {8'd0, c[REG_TURN_L]};
            MODE_RIGHT: return {c[REG_TURN_R], 8'd0};
            default:    return 16'd0;
        endcase
    endfunction

    // goal switch on a fix
    logic       sw_green;
    logic       aim_g;
    logic       aim_change;
    always_comb
    begin
        aim_g = green_reg;
        aim_change = 1'b0;
        sw_green = 1'b0;
        if (goal_y_reg == cfg_reg[REG_RED_Y] && {3'd0, py_reg} >= cfg_reg[REG_RED_Y])
        begin
            sw_green = 1'b1;
            aim_change = 1'b1;
            aim_g = 1'b1;
        end
        // second rule sees goal_y after the first
        if ((sw_green ? cfg_reg[REG_GREEN_Y] : goal_y_reg) == cfg_reg[REG_GREEN_Y]
            && {3'd0, py_reg} <= cfg_reg[REG_GREEN_Y])
        begin
            aim_change = 1'b1;
            aim_g = 1'b0;
        end
    end
    logic [7:0] new_gx, new_gy;
    assign new_gx = aim_change ? (aim_g ? cfg_reg[REG_GREEN_X] : cfg_reg[REG_RED_X]) : goal_x_reg;
    assign new_gy = aim_change ? (aim_g ? cfg_reg[REG_GREEN_Y] : cfg_reg[REG_RED_Y]) : goal_y_reg;

    logic signed [9:0] dx, dy;
    assign dx = $signed({2'b0, new_gx}) - $signed({5'b0, px_reg});
    assign dy = $signed({2'b0, new_gy}) - $signed({5'b0, py_reg});
    logic signed [VEC_W-1:0] vx, vy;
    assign vx = VEC_W'(dx) <<< 10;
    assign vy = VEC_W'(dy) <<< 10;

    // CORDIC step (>>> floors)
    logic signed [VEC_W-1:0] ys, xs;
    assign ys = y_reg >>> cmd.step;
    assign xs = x_reg >>> cmd.step;

    // error formation
    logic signed [ANG_W-1:0] z16;
    logic signed [ERR_W-1:0] b16, head, e0, e1;
    logic [ERR_W-1:0] mag;
    always_comb
    begin
        z16  = (z_reg + ANG_W'(8)) >>> 4;
        b16  = zero_reg ? '0 : ERR_W'(z16);
        head = $signed(ERR_W'(hc_reg) * ERR_W'(192));
        if (head > HALF_TURN16) head = head - FULL_TURN16;
        e0 = b16 - head;
        e1 = e0;
        if (e0 > HALF_TURN16) e1 = e0 - FULL_TURN16;
        else if (e0 < -HALF_TURN16) e1 = e0 + FULL_TURN16;
        mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    end

    // |err|/19 as (|err| * RECIP19) >> 16; |err| is at most 2880
    logic [25:0] prod;
    assign prod = 26'(mag) * 26'(RECIP19);
    assign stat.div_done = cmd.div;
    assign stat.is_fix   = (rcmd_reg == CMD_FIX) && started_reg;

    // decide
    mode_t      dec_mode;
    logic [31:0] dec_mst;
    logic        expire_tick;
    logic        expire_fix;
    always_comb
    begin
        dec_mode = (mag <= FWD_WINDOW16) ? MODE_FWD
                 : (err_reg > 0 ? MODE_LEFT : MODE_RIGHT);
        dec_mst  = tick_reg;
        expire_fix = (dec_mode == MODE_LEFT || dec_mode == MODE_RIGHT)
                   && (tick_reg > tick_reg + {24'd0, (mag <= FWD_WINDOW16) ? tlen_reg : quot_reg});
        expire_tick = (mode_reg == MODE_LEFT || mode_reg == MODE_RIGHT)
                   && (tick_reg + 32'd1 > mst_reg + {24'd0, tlen_reg});
    end

    logic [15:0] dr_next;
    always_comb
    begin
        mode_next = mode_reg;
        if (cmd.load)
        begin
            if (in_data[1:0] == CMD_TICK && started_reg && expire_tick) mode_next = MODE_FWD;
            if (in_data[1:0] == CMD_START) mode_next = MODE_FWD;
        end
        if (cmd.decide) mode_next = expire_fix ? MODE_FWD : dec_mode;
        dr_next = drives(mode_next, cfg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_STOP;
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
            green_reg   <= 1'b0;
            started_reg <= 1'b0;
            tick_reg    <= '0;
            mst_reg     <= '0;
            tlen_reg    <= '0;
            lm_reg      <= '0;
            rm_reg      <= '0;
            rcmd_reg    <= CMD_NONE;
        end
        else
        begin
            mode_reg <= mode_next;
            // an expiring turn passes through the turn mode, so forward reloads
            if (mode_next != mode_reg || (cmd.decide && expire_fix))
            begin
                lm_reg <= dr_next[7:0];
                rm_reg <= dr_next[15:8];
            end
            if (cmd.load)
            begin
                rcmd_reg <= in_data[1:0];
                if (in_data[1:0] == CMD_TICK)
                begin
                    tick_reg <= tick_reg + 32'd1;
                    if (started_reg && expire_tick) mst_reg <= tick_reg + 32'd1;
                end
                if (in_data[1:0] == CMD_START)
                begin
                    goal_x_reg  <= cfg_reg[REG_RED_X];
                    goal_y_reg  <= cfg_reg[REG_RED_Y];
                    green_reg   <= 1'b0;
                    started_reg <= 1'b1;
                end
            end
            if (cmd.aim && stat.is_fix)
            begin
                goal_x_reg <= new_gx;
                goal_y_reg <= new_gy;
                green_reg  <= aim_g;
            end
            if (cmd.decide)
            begin
                mst_reg <= dec_mst;
                if (mag > FWD_WINDOW16) tlen_reg <= quot_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= in_data[6:2];
            py_reg <= in_data[11:7];
            hc_reg <= in_data[16:12];
        end
        if (cmd.aim)
        begin
            zero_reg <= (dx == 0) && (dy == 0);
            if (vx < 0)
            begin
                x_reg <= -vx;
                y_reg <= -vy;
                z_reg <= (vy >= 0) ? HALF_TURN256 : -HALF_TURN256;
            end
            else
            begin
                x_reg <= vx;
                y_reg <= vy;
                z_reg <= '0;
            end
        end
        if (cmd.rot)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_entry(cmd.step);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_entry(cmd.step);
            end
        end
        if (cmd.err)
        begin
            err_reg <= e1;
        end
        if (cmd.div)
        begin
            quot_reg <= prod[23:16];
        end
    end

    assign left_drive  = lm_reg;
    assign right_drive = rm_reg;
    assign motion      = mode_reg;
    assign aim_green   = green_reg;

endmodule

// ===== src/goal_shuttle_steering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goal_shuttle_steering: top level
// Channel   | dir | payload
// s_axis    | in  | tdata: command, pos_x, pos_y, heading_code
// m_axis    | out | tdata: left_drive, right_drive, motion, aim_green
// cfg       | in  | cfg_we, cfg_index, cfg_data (8 registers)
// A tick, a start or an ignored request goes from acceptance through the aim
// and output states; a fix also passes the CORDIC, error, divide and decide
// states (14 CORDIC iterations, one multiply by the reciprocal of 19).
// One request at a time; the next is taken while the result waits in the
// output register. Reset is asynchronous; no clearing pass.
// ----------------------------------------------------------------------------
module goal_shuttle_steering
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // command[1:0], pos_x[6:2], pos_y[11:7], heading_code[16:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // left_drive[7:0], right_drive[15:8], motion[17:16], aim_green[18]
);
    import gss_pkg::*;

    gss_cmd_t  cmd;
    gss_stat_t stat;
    logic      res_load;
    logic [7:0] ld, rd;
    logic [1:0] mo;
    logic       ag;
    logic       ovalid_reg;
    logic [18:0] odata_reg;

    gss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .res_load (res_load),
        .res_busy (ovalid_reg && !m_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gss_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_we),
        .cfg_addr    (cfg_index),
        .cfg_data    (cfg_data),
        .in_data     (s_axis_tdata[16:0]),
        .cmd         (cmd),
        .stat        (stat),
        .left_drive  (ld),
        .right_drive (rd),
        .motion      (mo),
        .aim_green   (ag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (res_load)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load) odata_reg <= {ag, mo, rd, ld};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {5'd0, odata_reg};

endmodule

// ===== src/gss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_checker: port-level checks for goal_shuttle_steering
// Watches handshakes and output coding on the top level ports.
// ----------------------------------------------------------------------------
module gss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0)
        else $error("padding bits set");

    a_left: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[17:16] == 2'd3 |-> m_axis_tdata[7:0] == 8'd0)
        else $error("left drive while turning right");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken back to back");
endmodule

bind goal_shuttle_steering gss_checker u_gss_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
